// File: rtl/palc_pkg.sv
// Shared types, constants and helpers for the peer address LRU cache.
`default_nettype none

package palc_pkg;

    // Table geometry
    localparam int ENTRIES   = 20;
    localparam int TICK_BITS = 32;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MAC_W     = 48;
    localparam int NOW_W     = 32;
    localparam int SLOT_W    = 5;
    localparam int STATUS_W  = 3;

    // Request types
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_HIT        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ADD_FREE   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_ADD_EVICT  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ADD_REJ    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_REMOVED    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOT_CACHED = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_REM_REJ    = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              req_type;
        logic [MAC_W-1:0]  peer_mac;
        logic [NOW_W-1:0]  now_tick;
        logic              driver_ok;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic                evict_flag;
        logic [MAC_W-1:0]    evicted_mac;
    } t_out_item;

    // Running search result handed from cell to cell
    typedef struct packed {
        logic                 hit_found;
        logic [IDX_W-1:0]     hit_idx;
        logic                 free_found;
        logic [IDX_W-1:0]     free_idx;
        logic                 min_found;
        logic [IDX_W-1:0]     min_idx;
        logic [TICK_BITS-1:0] min_tick;
        logic [MAC_W-1:0]     min_mac;
    } t_acc;

    // Update command broadcast to all cells
    typedef struct packed {
        logic                 wr;
        logic                 refresh;
        logic                 clear;
        logic [IDX_W-1:0]     idx;
        logic [MAC_W-1:0]     mac;
        logic [TICK_BITS-1:0] tick;
    } t_cell_cmd;

    // Fit a tick sample to the stored timestamp width
    function automatic logic [TICK_BITS-1:0] tick_of(input logic [NOW_W-1:0] t);
        logic [TICK_BITS+NOW_W-1:0] w;
        w = {{TICK_BITS{1'b0}}, t};
        return w[TICK_BITS-1:0];
    endfunction

    // Fit a table index to the reported slot width
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, idx};
        return w[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/palc_cell.sv
// One table entry with its stage of the registered search chain.
`default_nettype none

module palc_cell
    import palc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_cell_idx,
    input  wire logic [MAC_W-1:0] i_req_mac,
    input  wire t_cell_cmd        i_cmd,
    input  wire t_acc             i_acc,
    output t_acc                  o_acc
);

    logic                 r_valid;
    logic [MAC_W-1:0]     r_mac;
    logic [TICK_BITS-1:0] r_tick;
    t_acc                 n_acc;
    logic                 sel;

    assign sel = (i_cmd.idx == i_cell_idx);

    // Hold the valid bit; clear it at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (sel && i_cmd.wr) begin
            r_valid <= 1'b1;
        end else if (sel && i_cmd.clear) begin
            r_valid <= 1'b0;
        end
    end

    // Store address and timestamp on write or refresh
    always_ff @(posedge i_clk) begin
        if (sel && i_cmd.wr) begin
            r_mac <= i_cmd.mac;
        end
        if (sel && (i_cmd.wr || i_cmd.refresh)) begin
            r_tick <= i_cmd.tick;
        end
    end

    // Merge this entry into the running result; earlier cells win ties
    always_comb begin
        n_acc = i_acc;
        if (r_valid && (r_mac == i_req_mac) && !i_acc.hit_found) begin
            n_acc.hit_found = 1'b1;
            n_acc.hit_idx   = i_cell_idx;
        end
        if (!r_valid && !i_acc.free_found) begin
            n_acc.free_found = 1'b1;
            n_acc.free_idx   = i_cell_idx;
        end
        if (r_valid && (!i_acc.min_found || (r_tick < i_acc.min_tick))) begin
            n_acc.min_found = 1'b1;
            n_acc.min_idx   = i_cell_idx;
            n_acc.min_tick  = r_tick;
            n_acc.min_mac   = r_mac;
        end
    end

    // Advance the result to the next cell
    always_ff @(posedge i_clk) begin
        o_acc <= n_acc;
    end

endmodule

`default_nettype wire

// File: rtl/peer_address_lru_cache_unit.sv
// Top level of the peer address LRU cache: request control and the cell chain.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  request | in        | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  result  | out       | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
// A request is first captured, then its search result ripples one cell per cycle
// down the chain of ENTRIES cells, and the commit step then updates the table and
// loads the result register.
// Reset clears all valid bits at once; addresses and timestamps are unset.
// A stalled result holds the commit step; a new request is taken only while
// the controller is idle, so one request can wait while a result is pending.
`default_nettype none

module peer_address_lru_cache_unit
    import palc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_cnt;
    t_in_item         r_req;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    t_cell_cmd        cmd;
    logic             out_load;
    logic             in_xfer;
    t_acc             acc_chain [0:ENTRIES];
    t_acc             fin;
    logic [IDX_W-1:0] chosen;
    logic             evict;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // Seed the chain with an empty result
    assign acc_chain[0] = '0;
    assign fin          = acc_chain[ENTRIES];

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        palc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_req_mac  (r_req.peer_mac),
            .i_cmd      (cmd),
            .i_acc      (acc_chain[g]),
            .o_acc      (acc_chain[g+1])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (r_cnt == IDX_W'(ENTRIES - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Decide the table update and the result
    always_comb begin
        chosen = fin.free_found ? fin.free_idx : fin.min_idx;
        evict  = !fin.free_found;
        cmd         = '0;
        cmd.mac     = r_req.peer_mac;
        cmd.tick    = tick_of(r_req.now_tick);
        n_out       = '0;
        if (r_req.req_type == REQ_ADD) begin
            if (fin.hit_found) begin
                n_out.status     = STAT_HIT;
                n_out.slot_index = slot_of(fin.hit_idx);
                cmd.idx          = fin.hit_idx;
                cmd.refresh      = out_load;
            end else begin
                n_out.slot_index = slot_of(chosen);
                n_out.evict_flag = evict;
                n_out.evicted_mac = evict ? fin.min_mac : '0;
                cmd.idx          = chosen;
                if (r_req.driver_ok) begin
                    n_out.status = evict ? STAT_ADD_EVICT : STAT_ADD_FREE;
                    cmd.wr       = out_load;
                end else begin
                    n_out.status = STAT_ADD_REJ;
                    cmd.clear    = out_load && evict;
                end
            end
        end else begin
            if (!r_req.driver_ok) begin
                n_out.status = STAT_REM_REJ;
            end else if (fin.hit_found) begin
                n_out.status     = STAT_REMOVED;
                n_out.slot_index = slot_of(fin.hit_idx);
                cmd.idx          = fin.hit_idx;
                cmd.clear        = out_load;
            end else begin
                n_out.status = STAT_NOT_CACHED;
            end
        end
    end

    // Advance the controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SEARCH) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Capture the request on transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req <= i_in_data;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // At most one table operation per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.wr, cmd.refresh, cmd.clear}))
        else $error("more than one table operation in a cycle");

    // Table changes only in the commit step
    a_cmd_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr || cmd.refresh || cmd.clear) |-> (r_state == ST_DONE) && out_load)
        else $error("table update outside the commit step");

    // Only eviction-type adds report an evicted address
    a_evict_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == STAT_HIT || r_out.status == STAT_ADD_FREE
                         || r_out.status == STAT_REMOVED
                         || r_out.status == STAT_NOT_CACHED
                         || r_out.status == STAT_REM_REJ))
        |-> (!r_out.evict_flag && (r_out.evicted_mac == '0)))
        else $error("evicted address reported without an eviction");

    // A new result is loaded only after the search ran its full length
    a_load_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && $rose(r_state == ST_DONE) |-> $past(r_state) == ST_SEARCH)
        else $error("result loaded without a completed search");

endmodule

`default_nettype wire

// File: verif/peer_address_lru_cache_unit_test.sv
// Self-checking testbench for the peer address LRU cache: directed table, random requests.
`timescale 1ns / 1ps

module peer_address_lru_cache_unit_test;
    import palc_pkg::*;

    localparam int RANDOM_REQUESTS = 1000;
    localparam int QUIET_TAIL      = 150;
    localparam int POOL_SIZE       = 26;
    localparam int SETTLE_CYCLES   = 2 * ENTRIES + 10;
    localparam int MAX_PRINTED     = 40;

    typedef struct {
        bit        tabled;
        t_out_item res;
    } t_tabled_answer;

    typedef struct {
        t_in_item  req;
        bit        tabled;
        t_out_item res;
    } t_directed_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Shadow copy of the peer table
    logic                 cached_valid [ENTRIES];
    logic [MAC_W-1:0]     cached_mac   [ENTRIES];
    logic [TICK_BITS-1:0] cached_tick  [ENTRIES];

    t_out_item      pending_cache_results [$];
    t_tabled_answer tabled_answers [$];
    t_directed_row  directed_rows [$];
    int             status_tally [8];
    int             error_count = 0;
    int             accepted_count = 0;
    int             idle_pct = 25;

    peer_address_lru_cache_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            cached_valid[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++) begin
            status_tally[i] = 0;
        end
    end

    function automatic t_in_item req_of(input logic op, input logic [MAC_W-1:0] mac,
                                        input logic [NOW_W-1:0] tick, input logic ok);
        t_in_item r;
        r.req_type  = op;
        r.peer_mac  = mac;
        r.now_tick  = tick;
        r.driver_ok = ok;
        return r;
    endfunction

    function automatic t_out_item res_of(input logic [STATUS_W-1:0] status,
                                         input logic [SLOT_W-1:0] slot);
        t_out_item r;
        r = '0;
        r.status     = status;
        r.slot_index = slot;
        return r;
    endfunction

    // Apply one request to the shadow table and return the result it causes
    function automatic t_out_item predict_cache_result(input t_in_item req);
        t_out_item            res;
        logic [TICK_BITS-1:0] stamp;
        int                   hit;
        int                   pick;
        res   = '0;
        stamp = TICK_BITS'(req.now_tick);
        hit   = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && cached_valid[i] && cached_mac[i] == req.peer_mac) begin
                hit = i;
            end
        end
        if (req.req_type == REQ_ADD) begin
            if (hit >= 0) begin
                // refresh only, driver verdict does not matter
                cached_tick[hit] = stamp;
                res.status       = STAT_HIT;
                res.slot_index   = hit[SLOT_W-1:0];
            end else begin
                pick = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (pick < 0 && !cached_valid[i]) begin
                        pick = i;
                    end
                end
                // table full: take the oldest entry, lowest slot on ties
                if (pick < 0) begin
                    pick = 0;
                    for (int i = 1; i < ENTRIES; i++) begin
                        if (cached_tick[i] < cached_tick[pick]) begin
                            pick = i;
                        end
                    end
                    res.evict_flag     = 1'b1;
                    res.evicted_mac    = cached_mac[pick];
                    cached_valid[pick] = 1'b0;
                end
                res.slot_index = pick[SLOT_W-1:0];
                if (req.driver_ok) begin
                    cached_mac[pick]   = req.peer_mac;
                    cached_tick[pick]  = stamp;
                    cached_valid[pick] = 1'b1;
                    res.status         = res.evict_flag ? STAT_ADD_EVICT : STAT_ADD_FREE;
                end else begin
                    res.status = STAT_ADD_REJ;
                end
            end
        end else if (!req.driver_ok) begin
            res.status = STAT_REM_REJ;
        end else if (hit >= 0) begin
            cached_valid[hit] = 1'b0;
            res.status        = STAT_REMOVED;
            res.slot_index    = hit[SLOT_W-1:0];
        end else begin
            res.status = STAT_NOT_CACHED;
        end
        return res;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
    endtask

    // Present one request and hold it until the transfer happens
    task automatic drive_request(input t_in_item req, input bit tabled, input t_out_item res);
        t_tabled_answer ans;
        int             gap;
        ans.tabled = tabled;
        ans.res    = res;
        tabled_answers.push_back(ans);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stall the result channel in random bursts
    initial begin : result_backpressure
        int burst;
        forever begin
            @(posedge i_clk);
            if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
                burst = $urandom_range(1, 10);
                i_out_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Check each result transfer, then predict for each request transfer
    always @(posedge i_clk) begin : transfer_monitor
        t_out_item      want;
        t_tabled_answer ans;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_cache_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 64'(o_out_data.status), 64'd0);
                end else begin
                    want = pending_cache_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", 64'(o_out_data.status), 64'(want.status));
                    if (o_out_data.slot_index !== want.slot_index)
                        report_mismatch("slot_index", 64'(o_out_data.slot_index),
                                        64'(want.slot_index));
                    if (o_out_data.evict_flag !== want.evict_flag)
                        report_mismatch("evict_flag", 64'(o_out_data.evict_flag),
                                        64'(want.evict_flag));
                    if (o_out_data.evicted_mac !== want.evicted_mac)
                        report_mismatch("evicted_mac", 64'(o_out_data.evicted_mac),
                                        64'(want.evicted_mac));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                ans  = tabled_answers.pop_front();
                want = predict_cache_result(i_in_data);
                if (ans.tabled) begin
                    want = ans.res;
                end
                status_tally[want.status]++;
                pending_cache_results.push_back(want);
                accepted_count++;
            end
        end
    end

    initial begin : stimulus
        logic [MAC_W-1:0] mac_pool [POOL_SIZE];
        logic [NOW_W-1:0] tick_now;
        logic [MAC_W-1:0] mac;
        logic             op;
        t_out_item        none;
        none = '0;

        // Hold reset, then release it once
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: empty table, extremes, hit, rejects, fill and evict
        directed_rows.push_back('{req_of(REQ_REMOVE, '0, '0, 1'b0), 1'b1,
                                  res_of(STAT_REM_REJ, 5'd0)});
        directed_rows.push_back('{req_of(REQ_REMOVE, '1, '1, 1'b1), 1'b1,
                                  res_of(STAT_NOT_CACHED, 5'd0)});
        directed_rows.push_back('{req_of(REQ_ADD, '0, '1, 1'b1), 1'b1,
                                  res_of(STAT_ADD_FREE, 5'd0)});
        directed_rows.push_back('{req_of(REQ_ADD, '1, '0, 1'b1), 1'b1,
                                  res_of(STAT_ADD_FREE, 5'd1)});
        directed_rows.push_back('{req_of(REQ_ADD, '0, 32'd5, 1'b0), 1'b1,
                                  res_of(STAT_HIT, 5'd0)});
        directed_rows.push_back('{req_of(REQ_ADD, 48'h0123_4567_89AB, 32'd6, 1'b0), 1'b1,
                                  res_of(STAT_ADD_REJ, 5'd2)});
        directed_rows.push_back('{req_of(REQ_REMOVE, '1, 32'd7, 1'b1), 1'b1,
                                  res_of(STAT_REMOVED, 5'd1)});
        // fill slots 1..19; slot 7 ties slot 0 on the oldest stamp
        for (int j = 1; j < ENTRIES; j++) begin
            directed_rows.push_back('{req_of(REQ_ADD, {16'h5A00 + 16'(j), 32'hC3C3_0000 ^ 32'(j)},
                                             (j == 7) ? 32'd5 : 32'd1000 + 32'(j), 1'b1),
                                      1'b0, none});
        end
        directed_rows.push_back('{req_of(REQ_ADD, 48'h8000_0000_0001, 32'd200, 1'b0),
                                  1'b0, none});
        directed_rows.push_back('{req_of(REQ_ADD, 48'h7FFF_FFFF_FFFE, '1, 1'b1), 1'b0, none});
        directed_rows.push_back('{req_of(REQ_ADD, 48'h0000_0001_0000, 32'd300, 1'b1),
                                  1'b0, none});
        foreach (directed_rows[k]) begin
            drive_request(directed_rows[k].req, directed_rows[k].tabled, directed_rows[k].res);
        end

        // Random part: mostly a recurring address pool so hits and evictions are common
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (int p = 2; p < POOL_SIZE; p++) begin
            mac_pool[p] = {16'($urandom), $urandom};
        end
        tick_now = 32'd2000;
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k < RANDOM_REQUESTS - QUIET_TAIL) begin
                idle_pct = ((k / 100) % 2 == 0) ? 25 : 0;
            end else begin
                idle_pct = 0;
            end
            case ($urandom_range(0, 19))
                0:       tick_now = $urandom;
                1:       tick_now = '1;
                2:       tick_now = '0;
                default: tick_now = tick_now + 32'($urandom_range(0, 3));
            endcase
            if ($urandom_range(0, 9) == 0) begin
                mac = {16'($urandom), $urandom};
                if ($urandom_range(0, 1) == 0) begin
                    mac_pool[$urandom_range(2, POOL_SIZE - 1)] = mac;
                end
            end else begin
                mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            op = ($urandom_range(0, 3) == 0) ? REQ_REMOVE : REQ_ADD;
            drive_request(req_of(op, mac, tick_now, $urandom_range(0, 7) != 0), 1'b0, none);
        end
        i_in_valid <= 1'b0;

        // Drain outstanding results, then let the block settle
        while (pending_cache_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d refresh hits, %0d free-slot adds, %0d evicting adds,",
                 accepted_count, status_tally[STAT_HIT], status_tally[STAT_ADD_FREE],
                 status_tally[STAT_ADD_EVICT]);
        $display("  %0d rejected adds, %0d removes, %0d uncached removes, %0d rejected removes",
                 status_tally[STAT_ADD_REJ], status_tally[STAT_REMOVED],
                 status_tally[STAT_NOT_CACHED], status_tally[STAT_REM_REJ]);
        if (error_count == 0) begin
            $display("peer_address_lru_cache_unit_test: PASS");
        end else begin
            $display("peer_address_lru_cache_unit_test: FAIL");
        end
        $finish;
    end

    // Abort a hung run
    initial begin : run_limit
        #10_000_000;
        $display("run limit reached with %0d results outstanding", pending_cache_results.size());
        $display("peer_address_lru_cache_unit_test: FAIL");
        $finish;
    end

endmodule
